// File: src/qrs_pkg.sv
// Shared types and widths for the quadratic root solver.
// Used by qrs_sqrt, qrs_div and quadratic_root_solver; depends on nothing.
`default_nettype none

package qrs_pkg;

  localparam int CoefW  = 16;          // Q8.8 coefficient
  localparam int RootW  = 32;          // Q16.16 root
  localparam int DiscW  = 34;          // signed raw discriminant
  localparam int SqrtW  = 31;          // bits of floor(sqrt(D * 2^28))
  localparam int RadW   = 2 * SqrtW;   // radicand width, one digit pair per stage
  localparam int FracW  = RadW - DiscW;  // zero bits appended below D
  localparam int NumW   = 34;          // numerator magnitude
  localparam int DenW   = 16;          // denominator magnitude
  localparam int DivLat = NumW + 1;    // quotient stages plus rounding stage

  typedef enum logic [2:0] {
    CaseTwo      = 3'd0,
    CaseDouble   = 3'd1,
    CaseLinear   = 3'd2,
    CaseNone     = 3'd3,
    CaseInfinite = 3'd4
  } case_e;

  // sideband that rides along the square root pipeline
  typedef struct packed {
    logic                    vld;
    case_e                   code;
    logic signed [CoefW-1:0] a;
    logic signed [CoefW-1:0] b;
    logic signed [CoefW-1:0] c;
  } side_sq_t;

  // sideband that rides along the divider pipeline
  typedef struct packed {
    logic  vld;
    case_e code;
  } side_dv_t;

endpackage

`default_nettype wire

// File: src/quadratic_root_solver.sv
// Top level of the pipelined quadratic root solver.
// Depends on qrs_pkg, qrs_sqrt and qrs_div.
//
// Usage:
//   Drive coef_a_i, coef_b_i, coef_c_i (signed Q8.8) and raise start. The
//   item is taken at every rising edge where start is high and busy is low;
//   busy is always low, so one item can be taken every cycle.
//   Each item yields exactly one result, shown for one cycle with done_o
//   high: case_code_o, root_plus_o, root_minus_o (signed Q16.16) and
//   saturated_o. Results leave in the order items came in.
//   Pipeline stages in order: input register, multiply, discriminant, 31
//   square root stages (one root bit each), numerator setup, 34 quotient
//   stages (one quotient bit each), rounding and clamp, output select.
//   Throughput: one item per cycle, set by the fully pipelined square root
//   and divider units.
//   Reset clears all valid bits; no result appears until an item is taken.
//   The receiver cannot stall: a result not taken in its cycle is gone.
`default_nettype none

module quadratic_root_solver (
  input  wire logic                      clk_i,
  input  wire logic                      rst_ni,
  input  wire logic                      start,
  output logic                           busy,
  input  wire logic [15:0]               coef_a_i,
  input  wire logic [15:0]               coef_b_i,
  input  wire logic [15:0]               coef_c_i,
  output logic                           done_o,
  output logic [2:0]                     case_code_o,
  output logic [31:0]                    root_plus_o,
  output logic [31:0]                    root_minus_o,
  output logic                           saturated_o
);

  localparam int CoefW = qrs_pkg::CoefW;
  localparam int DiscW = qrs_pkg::DiscW;
  localparam int SqrtW = qrs_pkg::SqrtW;
  localparam int NumW  = qrs_pkg::NumW;
  localparam int DenW  = qrs_pkg::DenW;
  localparam int WideW = NumW + 1;

  assign busy = 1'b0;

  // input register
  logic                    vld0_q;
  logic signed [CoefW-1:0] a0_q, b0_q, c0_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld0_q <= 1'b0;
    end else begin
      vld0_q <= start && !busy;
    end
  end

  always_ff @(posedge clk_i) begin
    a0_q <= coef_a_i;
    b0_q <= coef_b_i;
    c0_q <= coef_c_i;
  end

  // products b*b and a*c
  logic                      vld1_q;
  logic signed [CoefW-1:0]   a1_q, b1_q, c1_q;
  logic signed [2*CoefW-1:0] bb1_q, ac1_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld1_q <= 1'b0;
    end else begin
      vld1_q <= vld0_q;
    end
  end

  always_ff @(posedge clk_i) begin
    a1_q  <= a0_q;
    b1_q  <= b0_q;
    c1_q  <= c0_q;
    bb1_q <= b0_q * b0_q;
    ac1_q <= a0_q * c0_q;
  end

  // discriminant and case decision
  logic signed [DiscW-1:0] disc;
  qrs_pkg::case_e          code1;
  qrs_pkg::side_sq_t       side2_q;
  logic signed [DiscW-1:0] disc2_q;

  assign disc = DiscW'(bb1_q) - (DiscW'(ac1_q) <<< 2);

  always_comb begin
    if (a1_q == '0) begin
      if (b1_q != '0) begin
        code1 = qrs_pkg::CaseLinear;
      end else if (c1_q != '0) begin
        code1 = qrs_pkg::CaseNone;
      end else begin
        code1 = qrs_pkg::CaseInfinite;
      end
    end else if (disc < 0) begin
      code1 = qrs_pkg::CaseNone;
    end else if (disc == '0) begin
      code1 = qrs_pkg::CaseDouble;
    end else begin
      code1 = qrs_pkg::CaseTwo;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      side2_q <= '0;
    end else begin
      side2_q <= '{vld: vld1_q, code: code1, a: a1_q, b: b1_q, c: c1_q};
    end
  end

  always_ff @(posedge clk_i) begin
    disc2_q <= disc;
  end

  // square root of the discriminant, negative values feed zero
  logic [DiscW-2:0] rad;
  logic [SqrtW-1:0] sroot;

  assign rad = disc2_q[DiscW-1] ? '0 : disc2_q[DiscW-2:0];

  qrs_sqrt u_sqrt (
    .clk_i  (clk_i),
    .rad_i  (rad),
    .root_o (sroot)
  );

  qrs_pkg::side_sq_t side_sq_q [SqrtW];

  for (genvar k = 0; k < SqrtW; k++) begin : g_sq_line
    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        side_sq_q[k] <= '0;
      end else begin
        side_sq_q[k] <= (k == 0) ? side2_q : side_sq_q[(k == 0) ? 0 : k-1];
      end
    end
  end

  // numerators and denominator, split into magnitude and sign
  qrs_pkg::side_sq_t       sq;
  logic signed [WideW-1:0] bx, cx, s2x, base, n_p, n_m, np_sel;
  logic signed [DenW-1:0]  den_s;
  logic        [DenW:0]    den_ext;
  logic        [WideW-1:0] np_abs, nm_abs;

  assign sq   = side_sq_q[SqrtW-1];
  assign bx   = WideW'(sq.b);
  assign cx   = WideW'(sq.c);
  assign s2x  = $signed({{(WideW-SqrtW-1){1'b0}}, sroot, 1'b0});
  assign base = -(bx <<< 15);
  assign n_p  = base + s2x;
  assign n_m  = base - s2x;

  always_comb begin
    if (sq.a == '0) begin
      np_sel = -(cx <<< 16);
      den_s  = (sq.b == '0) ? DenW'(1) : sq.b;
    end else begin
      np_sel = n_p;
      den_s  = sq.a;
    end
  end

  assign np_abs  = np_sel[WideW-1] ? WideW'(-np_sel) : np_sel;
  assign nm_abs  = n_m[WideW-1] ? WideW'(-n_m) : n_m;
  assign den_ext = den_s[DenW-1] ? (DenW+1)'(-(DenW+1)'(den_s)) : (DenW+1)'(den_s);

  logic                side3_vld_q;
  qrs_pkg::case_e      side3_code_q;
  logic [NumW-1:0]     np3_q, nm3_q;
  logic [DenW-1:0]     den3_q;
  logic                negp3_q, negm3_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      side3_vld_q  <= 1'b0;
      side3_code_q <= qrs_pkg::CaseTwo;
    end else begin
      side3_vld_q  <= sq.vld;
      side3_code_q <= sq.code;
    end
  end

  always_ff @(posedge clk_i) begin
    np3_q   <= np_abs[NumW-1:0];
    nm3_q   <= nm_abs[NumW-1:0];
    den3_q  <= den_ext[DenW-1:0];
    negp3_q <= np_sel[WideW-1] ^ den_s[DenW-1];
    negm3_q <= n_m[WideW-1] ^ den_s[DenW-1];
  end

  // two dividers, plus root and minus root
  logic [31:0] rp, rm;
  logic        satp, satm;

  qrs_div u_div_p (
    .clk_i  (clk_i),
    .num_i  (np3_q),
    .den_i  (den3_q),
    .neg_i  (negp3_q),
    .root_o (rp),
    .sat_o  (satp)
  );

  qrs_div u_div_m (
    .clk_i  (clk_i),
    .num_i  (nm3_q),
    .den_i  (den3_q),
    .neg_i  (negm3_q),
    .root_o (rm),
    .sat_o  (satm)
  );

  qrs_pkg::side_dv_t side_dv_q [qrs_pkg::DivLat];

  for (genvar k = 0; k < qrs_pkg::DivLat; k++) begin : g_dv_line
    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        side_dv_q[k] <= '0;
      end else if (k == 0) begin
        side_dv_q[k] <= '{vld: side3_vld_q, code: side3_code_q};
      end else begin
        side_dv_q[k] <= side_dv_q[(k == 0) ? 0 : k-1];
      end
    end
  end

  // output select by case
  qrs_pkg::side_dv_t dv;
  logic              has_p, has_m;

  assign dv    = side_dv_q[qrs_pkg::DivLat-1];
  assign has_p = (dv.code == qrs_pkg::CaseTwo) || (dv.code == qrs_pkg::CaseDouble)
              || (dv.code == qrs_pkg::CaseLinear);
  assign has_m = (dv.code == qrs_pkg::CaseTwo);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      done_o <= 1'b0;
    end else begin
      done_o <= dv.vld;
    end
  end

  always_ff @(posedge clk_i) begin
    case_code_o  <= dv.code;
    root_plus_o  <= has_p ? rp : '0;
    root_minus_o <= has_m ? rm : '0;
    saturated_o  <= (has_p && satp) || (has_m && satm);
  end

endmodule

`default_nettype wire

// File: src/qrs_sqrt.sv
// Pipelined integer square root, one result bit per register stage.
// Depends on qrs_pkg for widths.
`default_nettype none

module qrs_sqrt (
  input  wire logic                         clk_i,
  input  wire logic [qrs_pkg::DiscW-2:0]    rad_i,
  output logic      [qrs_pkg::SqrtW-1:0]    root_o
);

  localparam int RemW = qrs_pkg::SqrtW + 3;

  logic [RemW-1:0]          rem_q  [qrs_pkg::SqrtW-1];
  logic [qrs_pkg::RadW-1:0] v_q    [qrs_pkg::SqrtW-1];
  logic [qrs_pkg::SqrtW-1:0] root_q [qrs_pkg::SqrtW];

  for (genvar k = 0; k < qrs_pkg::SqrtW; k++) begin : g_st
    logic [RemW-1:0]           rem_in, rem_sh, trial;
    logic [qrs_pkg::SqrtW-1:0] root_in;
    logic [qrs_pkg::RadW-1:0]  v_in;
    logic                      ge;

    if (k == 0) begin : g_first
      assign rem_in  = '0;
      assign root_in = '0;
      assign v_in    = {1'b0, rad_i, {qrs_pkg::FracW{1'b0}}};
    end else begin : g_next
      assign rem_in  = rem_q[k-1];
      assign root_in = root_q[k-1];
      assign v_in    = v_q[k-1];
    end

    // bring down the next digit pair, try (4*root + 1)
    assign rem_sh = {rem_in[RemW-3:0], v_in[qrs_pkg::RadW-1 -: 2]};
    assign trial  = {1'b0, root_in, 2'b01};
    assign ge     = (rem_sh >= trial);

    always_ff @(posedge clk_i) begin
      root_q[k] <= {root_in[qrs_pkg::SqrtW-2:0], ge};
    end

    if (k < qrs_pkg::SqrtW - 1) begin : g_carry
      always_ff @(posedge clk_i) begin
        rem_q[k] <= ge ? (rem_sh - trial) : rem_sh;
        v_q[k]   <= {v_in[qrs_pkg::RadW-3:0], 2'b00};
      end
    end
  end

  assign root_o = root_q[qrs_pkg::SqrtW-1];

endmodule

`default_nettype wire

// File: src/qrs_div.sv
// Pipelined restoring divider with round-half-away and Q16.16 clamp.
// Depends on qrs_pkg for widths.
`default_nettype none

module qrs_div (
  input  wire logic                       clk_i,
  input  wire logic [qrs_pkg::NumW-1:0]   num_i,
  input  wire logic [qrs_pkg::DenW-1:0]   den_i,
  input  wire logic                       neg_i,
  output logic      [qrs_pkg::RootW-1:0]  root_o,
  output logic                            sat_o
);

  localparam int NumW = qrs_pkg::NumW;
  localparam int DenW = qrs_pkg::DenW;

  logic [DenW-1:0] rem_q [NumW];
  logic [NumW-1:0] q_q   [NumW];
  logic [NumW-1:0] num_q [NumW-1];
  logic [DenW-1:0] den_q [NumW];
  logic            neg_q [NumW];

  for (genvar k = 0; k < NumW; k++) begin : g_st
    logic [DenW-1:0] rem_in, den_in;
    logic [NumW-1:0] q_in, n_in;
    logic            neg_in, ge;
    logic [DenW:0]   rem_sh;

    if (k == 0) begin : g_first
      assign rem_in = '0;
      assign q_in   = '0;
      assign n_in   = num_i;
      assign den_in = den_i;
      assign neg_in = neg_i;
    end else begin : g_next
      assign rem_in = rem_q[k-1];
      assign q_in   = q_q[k-1];
      assign n_in   = num_q[k-1];
      assign den_in = den_q[k-1];
      assign neg_in = neg_q[k-1];
    end

    // shift in one numerator bit, subtract when it fits
    assign rem_sh = {rem_in, n_in[NumW-1]};
    assign ge     = (rem_sh >= {1'b0, den_in});

    always_ff @(posedge clk_i) begin
      rem_q[k] <= ge ? DenW'(rem_sh - {1'b0, den_in}) : rem_sh[DenW-1:0];
      q_q[k]   <= {q_in[NumW-2:0], ge};
      den_q[k] <= den_in;
      neg_q[k] <= neg_in;
    end

    if (k < NumW - 1) begin : g_carry
      always_ff @(posedge clk_i) begin
        num_q[k] <= {n_in[NumW-2:0], 1'b0};
      end
    end
  end

  // round to nearest, ties away from zero, then apply sign and clamp
  logic          up;
  logic [NumW:0] qr;
  localparam logic [NumW:0] PosMax = (NumW+1)'(33'h0_7FFF_FFFF);
  localparam logic [NumW:0] NegMax = (NumW+1)'(33'h0_8000_0000);

  assign up = ({rem_q[NumW-1], 1'b0} >= {1'b0, den_q[NumW-1]});
  assign qr = {1'b0, q_q[NumW-1]} + (NumW+1)'(up);

  always_ff @(posedge clk_i) begin
    if (!neg_q[NumW-1]) begin
      if (qr > PosMax) begin
        root_o <= 32'h7FFF_FFFF;
        sat_o  <= 1'b1;
      end else begin
        root_o <= qr[qrs_pkg::RootW-1:0];
        sat_o  <= 1'b0;
      end
    end else begin
      if (qr > NegMax) begin
        root_o <= 32'h8000_0000;
        sat_o  <= 1'b1;
      end else begin
        root_o <= 32'(-qr[qrs_pkg::RootW-1:0]);
        sat_o  <= 1'b0;
      end
    end
  end

endmodule

`default_nettype wire

// File: tb/tb_quadratic_root_solver.sv
// Testbench for quadratic_root_solver: directed and random coefficient sets,
// roots predicted in fixed point and checked in order. Depends on qrs_pkg.
`default_nettype none

module tb_quadratic_root_solver;
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct {
    qrs_pkg::case_e code;
    logic [31:0]    rp;
    logic [31:0]    rm;
    logic           sat;
  } roots_t;

  logic        clk_i;
  logic        rst_ni;
  logic        start;
  logic        busy;
  logic [15:0] coef_a_i, coef_b_i, coef_c_i;
  logic        done_o;
  logic [2:0]  case_code_o;
  logic [31:0] root_plus_o, root_minus_o;
  logic        saturated_o;

  roots_t pending_roots[$];
  int     errors = 0;
  bit     quiet_mode = 0;

  quadratic_root_solver u_top (
    .clk_i(clk_i), .rst_ni(rst_ni), .start(start), .busy(busy),
    .coef_a_i(coef_a_i), .coef_b_i(coef_b_i), .coef_c_i(coef_c_i),
    .done_o(done_o), .case_code_o(case_code_o), .root_plus_o(root_plus_o),
    .root_minus_o(root_minus_o), .saturated_o(saturated_o)
  );

  initial begin
    clk_i = 0;
    forever #5 clk_i = ~clk_i;
  end

  // integer square root, bit pair at a time
  function automatic longint unsigned int_sqrt(longint unsigned v);
    longint unsigned res, bitv;
    res = 0;
    bitv = 64'd1 << 62;
    while (bitv > v) bitv = bitv >> 2;
    while (bitv != 0) begin
      if (v >= res + bitv) begin
        v = v - (res + bitv);
        res = (res >> 1) + bitv;
      end else begin
        res = res >> 1;
      end
      bitv = bitv >> 2;
    end
    return res;
  endfunction

  // divide, round to nearest with ties away from zero
  function automatic longint div_nearest(longint num, longint den);
    longint unsigned un, ud, q, r;
    bit neg;
    neg = (num < 0) != (den < 0);
    un = num < 0 ? -num : num;
    ud = den < 0 ? -den : den;
    q = un / ud;
    r = un % ud;
    if (r >= ud - r) q++;
    return neg ? -longint'(q) : longint'(q);
  endfunction

  function automatic logic [31:0] clamp_q16(longint v, ref logic sat);
    if (v > 64'sd2147483647) begin
      sat = 1;
      return 32'h7fff_ffff;
    end
    if (v < -64'sd2147483648) begin
      sat = 1;
      return 32'h8000_0000;
    end
    return v[31:0];
  endfunction

  function automatic roots_t solve_roots(logic [15:0] ar, logic [15:0] br,
                                         logic [15:0] cr);
    roots_t r;
    longint a, b, c, d, s, base;
    logic sat;
    a = longint'($signed(ar));
    b = longint'($signed(br));
    c = longint'($signed(cr));
    r.rp = 0;
    r.rm = 0;
    sat = 0;
    if (a == 0) begin
      if (b != 0) begin
        r.code = qrs_pkg::CaseLinear;
        r.rp = clamp_q16(div_nearest(-c * 65536, b), sat);
      end else if (c != 0) begin
        r.code = qrs_pkg::CaseNone;
      end else begin
        r.code = qrs_pkg::CaseInfinite;
      end
    end else begin
      d = b * b - 4 * a * c;
      if (d < 0) begin
        r.code = qrs_pkg::CaseNone;
      end else begin
        s = longint'(int_sqrt(longint'(d) << 28));
        base = -b * 16384;
        if (d == 0) begin
          r.code = qrs_pkg::CaseDouble;
          r.rp = clamp_q16(div_nearest(2 * base, a), sat);
        end else begin
          r.code = qrs_pkg::CaseTwo;
          r.rp = clamp_q16(div_nearest(2 * (base + s), a), sat);
          r.rm = clamp_q16(div_nearest(2 * (base - s), a), sat);
        end
      end
    end
    r.sat = sat;
    return r;
  endfunction

  // send one item, predict its roots at acceptance
  task automatic send_coefs(logic [15:0] a, logic [15:0] b, logic [15:0] c);
    if (!quiet_mode && $urandom_range(99) < 6) begin
      start <= 0;
      repeat ($urandom_range(1, 2)) @(negedge clk_i);
    end
    start <= 1;
    coef_a_i <= a;
    coef_b_i <= b;
    coef_c_i <= c;
    do @(posedge clk_i); while (busy);
    pending_roots.push_back(solve_roots(a, b, c));
    @(negedge clk_i);
  endtask

  // result checker
  always @(posedge clk_i) begin
    roots_t e;
    if (rst_ni && done_o) begin
      if (pending_roots.size() == 0) begin
        $display("%0t: result with none expected: code %0d", $time, case_code_o);
        errors++;
      end else begin
        e = pending_roots.pop_front();
        if (case_code_o !== e.code) begin
          $display("%0t: case_code exp %0d got %0d", $time, e.code, case_code_o);
          errors++;
        end
        if (root_plus_o !== e.rp) begin
          $display("%0t: root_plus exp %h got %h", $time, e.rp, root_plus_o);
          errors++;
        end
        if (root_minus_o !== e.rm) begin
          $display("%0t: root_minus exp %h got %h", $time, e.rm, root_minus_o);
          errors++;
        end
        if (saturated_o !== e.sat) begin
          $display("%0t: saturated exp %0d got %0d", $time, e.sat, saturated_o);
          errors++;
        end
      end
    end
  end

  task automatic test_linear_cases();
    send_coefs(16'h0000, 16'h0100, 16'h0200);
    send_coefs(16'h0000, 16'h0000, 16'h0100);
    send_coefs(16'h0000, 16'h0000, 16'h0000);
    send_coefs(16'h0000, 16'h0001, 16'h7fff);   // near the low limit, no saturation
    send_coefs(16'h0000, 16'h0001, 16'h8000);   // saturates high
    send_coefs(16'h0000, 16'hffff, 16'h7fff);
    send_coefs(16'h0000, 16'h8000, 16'h8000);
  endtask

  task automatic test_quadratic_cases();
    send_coefs(16'h0100, 16'h0000, 16'hff00);   // x^2 - 1: two roots
    send_coefs(16'h0100, 16'h0200, 16'h0100);   // double root
    send_coefs(16'h0100, 16'h0000, 16'h0100);   // no real root
    send_coefs(16'h0001, 16'h7fff, 16'h0000);   // huge root near the low limit, no saturation
    send_coefs(16'h0001, 16'h8000, 16'h0000);
    send_coefs(16'h8000, 16'h8000, 16'h7fff);
    send_coefs(16'h7fff, 16'h7fff, 16'h8000);
    send_coefs(16'h8000, 16'h0000, 16'h8000);
    send_coefs(16'hffff, 16'hffff, 16'hffff);
    send_coefs(16'h0001, 16'h0002, 16'h0001);   // double root, small a
    send_coefs(16'h7fff, 16'h0000, 16'h0000);   // double root at zero
  endtask

  task automatic test_random_coefs(int count);
    logic [15:0] a, b, c;
    int k;
    for (int i = 0; i < count; i++) begin
      quiet_mode = (i >= count / 2) && (i < count / 2 + 300);
      a = 16'($urandom);
      b = 16'($urandom);
      c = 16'($urandom);
      k = $urandom_range(9);
      if (k == 0) a = 0;
      if (k == 1) begin
        // small a, b, c give a mix of cases
        a = 16'($signed(8'($urandom)));
        b = 16'($signed(8'($urandom)));
        c = 16'($signed(8'($urandom)));
      end
      if (k == 2) begin
        // perfect square: a(x-r)^2 with b^2 = 4ac
        a = 16'($urandom_range(1, 64));
        c = a;
        b = (($urandom & 1) ? 16'(2 * a) : -16'(2 * a));
      end
      send_coefs(a, b, c);
    end
    quiet_mode = 0;
  endtask

  initial begin
    rst_ni = 0;
    start = 0;
    coef_a_i = 0;
    coef_b_i = 0;
    coef_c_i = 0;
    repeat (4) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1;
    test_linear_cases();
    test_quadratic_cases();
    test_random_coefs(1600);
    start <= 0;
    wait (pending_roots.size() == 0);
    repeat (80) @(posedge clk_i);
    if (errors == 0 && pending_roots.size() == 0) begin
      $display("tb_quadratic_root_solver OK");
    end else begin
      $display("tb_quadratic_root_solver NOT OK");
    end
    $finish;
  end

  initial begin
    #2ms;
    $display("tb_quadratic_root_solver NOT OK");
    $finish;
  end

endmodule

`default_nettype wire

// File: quadratic_root_solver.f
src/qrs_pkg.sv
src/qrs_sqrt.sv
src/qrs_div.sv
src/quadratic_root_solver.sv
tb/tb_quadratic_root_solver.sv
